// ===== sv/layer_color_blend_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef LAYER_COLOR_BLEND_UNIT_DEFINES_SVH
`define LAYER_COLOR_BLEND_UNIT_DEFINES_SVH

// checked only outside reset
`define LCBU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LCBU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lcbu_pkg.sv =====
`default_nettype none
package lcbu_pkg;

   // channel constants, unsigned 1.15 fixed point
   localparam logic [15:0] FULL_VAL = 16'h8000;
   localparam logic [15:0] HALF_VAL = 16'h4000;

   // pipeline shape: front stages, one divider stage per quotient bit, final stage
   localparam int QBITS       = 17;
   localparam int FRONT_STAGES = 5;
   localparam int NUM_STAGES  = FRONT_STAGES + QBITS + 1;

   localparam logic [4:0] MODE_COUNT = 5'd19;

   typedef enum logic [4:0] {
      MODE_NORMAL       = 5'd0,
      MODE_MULTIPLY     = 5'd1,
      MODE_ADD          = 5'd2,
      MODE_SUBTRACT     = 5'd3,
      MODE_SCREEN       = 5'd4,
      MODE_OVERLAY      = 5'd5,
      MODE_HARD_LIGHT   = 5'd6,
      MODE_SOFT_LIGHT   = 5'd7,
      MODE_DODGE        = 5'd8,
      MODE_BURN         = 5'd9,
      MODE_LINEAR_BURN  = 5'd10,
      MODE_VIVID_LIGHT  = 5'd11,
      MODE_LINEAR_LIGHT = 5'd12,
      MODE_PIN_LIGHT    = 5'd13,
      MODE_DARKEN       = 5'd14,
      MODE_LIGHTEN      = 5'd15,
      MODE_DIFFERENCE   = 5'd16,
      MODE_LUM_ADD      = 5'd17,
      MODE_LUM_DODGE    = 5'd18
   } mode_type;

   // per-channel side information that travels beside the divider
   typedef struct packed {
      logic [15:0] base;
      logic        use_div;
      logic        burn;
      logic        lum;
   } carry_type;

   // clamp an input channel to full scale
   function automatic logic [15:0] sat_in(input logic [15:0] v);
      sat_in = (v > FULL_VAL) ? FULL_VAL : v;
   endfunction

   // clamp a signed intermediate to 0..full
   function automatic logic [15:0] sat_out(input logic signed [19:0] v);
      logic signed [19:0] full_s;
      full_s = signed'({4'b0, FULL_VAL});
      if (v < 20'sd0) begin
         sat_out = 16'd0;
      end else if (v > full_s) begin
         sat_out = FULL_VAL;
      end else begin
         sat_out = v[15:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== sv/lcbu_div.sv =====
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, msb first
module lcbu_div (
   input  wire logic                       clock,
   input  wire logic                       pipe_en,
   input  wire logic [30:0]                num_i,
   input  wire logic [15:0]                den_i,
   output logic [lcbu_pkg::QBITS-1:0]      quo_o
);

   localparam int QB = lcbu_pkg::QBITS;

   logic [30:0]   rem_ff [QB];
   logic [15:0]   den_ff [QB];
   logic [QB-1:0] quo_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_stage
      logic [30:0]   rem_prev;
      logic [15:0]   den_prev;
      logic [QB-1:0] quo_prev;
      logic [32:0]   dsh;
      logic [32:0]   rem_ext;
      logic [30:0]   rem_in;
      logic [QB-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = num_i;
         assign den_prev = den_i;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
         dsh     = 33'(den_prev) << (QB - 1 - j);
         rem_ext = {2'b0, rem_prev};
         rem_in  = rem_prev;
         quo_in  = quo_prev;
         if (rem_ext >= dsh) begin
            rem_in             = 31'(rem_ext - dsh);
            quo_in[QB - 1 - j] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_prev;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quo_o = quo_ff[QB-1];

endmodule
`default_nettype wire

// ===== sv/lcbu_lane.sv =====
`default_nettype none
// one color channel: saturate, scale, multiply, mode select, divide, finish
module lcbu_lane (
   input  wire logic        clock,
   input  wire logic        pipe_en,
   input  wire logic [4:0]  mode_i,
   input  wire logic [15:0] src_i,
   input  wire logic [15:0] dst_i,
   input  wire logic [15:0] alpha_i,
   output logic [15:0]      res_o,
   output logic             alpha_applied_o
);

   localparam int QB = lcbu_pkg::QBITS;
   localparam logic [15:0] FULL = lcbu_pkg::FULL_VAL;
   localparam logic [15:0] HALF = lcbu_pkg::HALF_VAL;
   localparam logic signed [19:0] FULL_S = 20'sd32768;

   // stage 1: input saturation and mode decode
   lcbu_pkg::mode_type s1_mode_ff, s1_mode_in;
   logic [15:0] s1_s_ff, s1_d_ff, s1_a_ff;

   always_comb begin
      if (mode_i >= lcbu_pkg::MODE_COUNT) begin
         s1_mode_in = lcbu_pkg::MODE_NORMAL;
      end else begin
         s1_mode_in = lcbu_pkg::mode_type'(mode_i);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_mode_ff <= s1_mode_in;
         s1_s_ff    <= lcbu_pkg::sat_in(src_i);
         s1_d_ff    <= lcbu_pkg::sat_in(dst_i);
         s1_a_ff    <= lcbu_pkg::sat_in(alpha_i);
      end
   end

   // stage 2: alpha scaling of the source for the luminous modes
   lcbu_pkg::mode_type s2_mode_ff;
   logic [15:0] s2_s_ff, s2_d_ff, s2_s_in;
   logic [31:0] prod_a;
   logic        s1_lum;

   always_comb begin
      s1_lum  = (s1_mode_ff == lcbu_pkg::MODE_LUM_ADD) ||
                (s1_mode_ff == lcbu_pkg::MODE_LUM_DODGE);
      prod_a  = 32'(s1_s_ff) * 32'(s1_a_ff);
      s2_s_in = s1_lum ? prod_a[30:15] : s1_s_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_mode_ff <= s1_mode_ff;
         s2_s_ff    <= s2_s_in;
         s2_d_ff    <= s1_d_ff;
      end
   end

   // stage 3: direct and inverted products
   lcbu_pkg::mode_type s3_mode_ff;
   logic [15:0] s3_s_ff, s3_d_ff;
   logic [30:0] s3_p1_ff, s3_p2_ff;
   logic [31:0] p1_full, p2_full;

   always_comb begin
      p1_full = 32'(s2_s_ff) * 32'(s2_d_ff);
      p2_full = 32'(FULL - s2_s_ff) * 32'(FULL - s2_d_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_mode_ff <= s2_mode_ff;
         s3_s_ff    <= s2_s_ff;
         s3_d_ff    <= s2_d_ff;
         s3_p1_ff   <= p1_full[30:0];
         s3_p2_ff   <= p2_full[30:0];
      end
   end

   // stage 4: per-mode result and divider operands
   lcbu_pkg::mode_type s4_mode_ff;
   logic [15:0] s4_d_ff, s4_n_ff, s4_t_ff, s4_base_ff, s4_den_ff;
   logic [30:0] s4_num_ff;
   logic        s4_use_ff, s4_burn_ff;

   logic signed [19:0] ss, dd, nn, raw, pin;
   logic signed [16:0] tt;
   logic [15:0] t_in, den_in, nl;
   logic [16:0] nh;
   logic [30:0] num_in;
   logic        use_in, burn_in;

   always_comb begin
      ss      = signed'({4'b0, s3_s_ff});
      dd      = signed'({4'b0, s3_d_ff});
      nn      = signed'({4'b0, s3_p1_ff[30:15]});
      tt      = signed'({1'b0, FULL}) - signed'({1'b0, s3_p1_ff[30:15]})
                - signed'({1'b0, s3_p2_ff[30:15]});
      t_in    = tt[16] ? 16'd0 : tt[15:0];
      raw     = ss;
      use_in  = 1'b0;
      burn_in = 1'b0;
      num_in  = '0;
      den_in  = 16'd1;
      nl      = FULL - {s3_s_ff[14:0], 1'b0};
      nh      = 17'h10000 - {s3_s_ff, 1'b0};
      pin     = (ss <<< 1) - FULL_S;
      case (s3_mode_ff)
         lcbu_pkg::MODE_MULTIPLY:     raw = nn;
         lcbu_pkg::MODE_ADD:          raw = ss + dd;
         lcbu_pkg::MODE_SUBTRACT:     raw = dd - ss;
         lcbu_pkg::MODE_SCREEN:       raw = ss + dd - nn;
         lcbu_pkg::MODE_OVERLAY: begin
            if (s3_d_ff < HALF) begin
               raw = signed'({3'b0, s3_p1_ff[30:14]});
            end else begin
               raw = FULL_S - signed'({3'b0, s3_p2_ff[30:14]});
            end
         end
         lcbu_pkg::MODE_HARD_LIGHT: begin
            if (s3_s_ff < HALF) begin
               raw = signed'({3'b0, s3_p1_ff[30:14]});
            end else begin
               raw = FULL_S - signed'({3'b0, s3_p2_ff[30:14]});
            end
         end
         lcbu_pkg::MODE_SOFT_LIGHT:   raw = 20'sd0;
         lcbu_pkg::MODE_DODGE,
         lcbu_pkg::MODE_LUM_DODGE: begin
            if (s3_s_ff == FULL) begin
               raw = FULL_S;
            end else begin
               use_in = 1'b1;
               num_in = {s3_d_ff, 15'b0};
               den_in = FULL - s3_s_ff;
            end
         end
         lcbu_pkg::MODE_BURN: begin
            if (s3_s_ff == 16'd0) begin
               raw = 20'sd0;
            end else begin
               use_in  = 1'b1;
               burn_in = 1'b1;
               num_in  = {FULL - s3_d_ff, 15'b0};
               den_in  = s3_s_ff;
            end
         end
         lcbu_pkg::MODE_LINEAR_BURN:  raw = dd + ss - FULL_S;
         lcbu_pkg::MODE_VIVID_LIGHT: begin
            if (s3_s_ff < HALF) begin
               if (s3_s_ff == 16'd0 || s3_d_ff <= nl) begin
                  raw = 20'sd0;
               end else begin
                  use_in = 1'b1;
                  num_in = {s3_d_ff - nl, 15'b0};
                  den_in = {s3_s_ff[14:0], 1'b0};
               end
            end else begin
               if (nh == 17'd0 || {1'b0, s3_d_ff} >= nh) begin
                  raw = FULL_S;
               end else begin
                  use_in = 1'b1;
                  num_in = {s3_d_ff, 15'b0};
                  den_in = nh[15:0];
               end
            end
         end
         lcbu_pkg::MODE_LINEAR_LIGHT: raw = (ss <<< 1) + dd - FULL_S;
         lcbu_pkg::MODE_PIN_LIGHT: begin
            if (s3_s_ff > HALF) begin
               raw = (pin < dd) ? dd : pin;
            end else begin
               raw = ((ss <<< 1) > dd) ? dd : (ss <<< 1);
            end
         end
         lcbu_pkg::MODE_DARKEN:       raw = (dd < ss) ? dd : ss;
         lcbu_pkg::MODE_LIGHTEN:      raw = (dd > ss) ? dd : ss;
         lcbu_pkg::MODE_DIFFERENCE:   raw = (ss >= dd) ? ss - dd : dd - ss;
         lcbu_pkg::MODE_LUM_ADD:      raw = ss + dd;
         default:                     raw = ss;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_mode_ff <= s3_mode_ff;
         s4_d_ff    <= s3_d_ff;
         s4_n_ff    <= s3_p1_ff[30:15];
         s4_t_ff    <= t_in;
         s4_base_ff <= lcbu_pkg::sat_out(raw);
         s4_use_ff  <= use_in;
         s4_burn_ff <= burn_in;
         s4_num_ff  <= num_in;
         s4_den_ff  <= den_in;
      end
   end

   // stage 5: soft light product, quotient overflow check
   lcbu_pkg::carry_type s5_carry_ff, s5_carry_in;
   logic [30:0] s5_num_ff;
   logic [15:0] s5_den_ff;
   logic [31:0] dt;
   logic [16:0] soft_sum;
   logic [15:0] soft_sat;
   logic        ovf;

   always_comb begin
      dt       = 32'(s4_d_ff) * 32'(s4_t_ff);
      soft_sum = {1'b0, s4_n_ff} + {1'b0, dt[30:15]};
      soft_sat = (soft_sum > {1'b0, FULL}) ? FULL : soft_sum[15:0];
      ovf      = {2'b0, s4_num_ff} >= {s4_den_ff, 17'b0};
      s5_carry_in.use_div = s4_use_ff && !ovf;
      s5_carry_in.burn    = s4_burn_ff;
      s5_carry_in.lum     = (s4_mode_ff == lcbu_pkg::MODE_LUM_ADD) ||
                            (s4_mode_ff == lcbu_pkg::MODE_LUM_DODGE);
      if (s4_mode_ff == lcbu_pkg::MODE_SOFT_LIGHT) begin
         s5_carry_in.base = soft_sat;
      end else if (s4_use_ff && ovf) begin
         s5_carry_in.base = s4_burn_ff ? 16'd0 : FULL;
      end else begin
         s5_carry_in.base = s4_base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_carry_ff <= s5_carry_in;
         s5_num_ff   <= s4_num_ff;
         s5_den_ff   <= s4_den_ff;
      end
   end

   // divider and the side line that runs beside it
   logic [QB-1:0] quo;
   lcbu_pkg::carry_type carry_ff [QB];

   lcbu_div u_div (
      .clock   (clock),
      .pipe_en (pipe_en),
      .num_i   (s5_num_ff),
      .den_i   (s5_den_ff),
      .quo_o   (quo)
   );

   for (genvar j = 0; j < QB; j++) begin : g_carry
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               carry_ff[j] <= s5_carry_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               carry_ff[j] <= carry_ff[j-1];
            end
         end
      end
   end

   // final stage: clamp the quotient and pick the result
   lcbu_pkg::carry_type last_c;
   logic [15:0] q_sat, res_in, res_ff;
   logic        flag_ff;

   always_comb begin
      last_c = carry_ff[QB-1];
      q_sat  = (quo > QB'(FULL)) ? FULL : quo[15:0];
      if (last_c.use_div) begin
         res_in = last_c.burn ? FULL - q_sat : q_sat;
      end else begin
         res_in = last_c.base;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         res_ff  <= res_in;
         flag_ff <= last_c.lum;
      end
   end

   assign res_o           = res_ff;
   assign alpha_applied_o = flag_ff;

endmodule
`default_nettype wire

// ===== sv/layer_color_blend_unit.sv =====
// an accepted word passes through the lane front stages, the divider stages and the final stage to its result word
// throughput: one pixel word per cycle while the skid is empty; the divider is pipelined one quotient bit per stage
// a one-word skid register at the output takes a stalled result word; the input stalls while the skid holds it
// reset (synchronous, active high) clears the valid bits and the skid valid bit and sets the blend mode to normal
`default_nettype none
module layer_color_blend_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [4:0]  csr_blend_mode,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_src_red,
   input  wire logic [15:0] req_src_green,
   input  wire logic [15:0] req_src_blue,
   input  wire logic [15:0] req_dst_red,
   input  wire logic [15:0] req_dst_green,
   input  wire logic [15:0] req_dst_blue,
   input  wire logic [15:0] req_src_alpha,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_out_red,
   output logic [15:0]      rsp_out_green,
   output logic [15:0]      rsp_out_blue,
   output logic             rsp_alpha_applied
);

   localparam int NS = lcbu_pkg::NUM_STAGES;

   // blend mode register
   logic [4:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lcbu_pkg::MODE_NORMAL;
      end else if (csr_write_enable) begin
         mode_ff <= csr_blend_mode;
      end
   end

   // pipeline moves as a whole unless the skid is holding a word
   logic          skid_v_ff;
   logic          pipe_en;
   logic [NS-1:0] v_ff;

   assign pipe_en   = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (pipe_en) begin
         v_ff <= {v_ff[NS-2:0], req_valid};
      end
   end

   // channel lanes
   logic [15:0] red, green, blue;
   logic        lum;

   lcbu_lane u_red (
      .clock           (clock),
      .pipe_en         (pipe_en),
      .mode_i          (mode_ff),
      .src_i           (req_src_red),
      .dst_i           (req_dst_red),
      .alpha_i         (req_src_alpha),
      .res_o           (red),
      .alpha_applied_o (lum)
   );

   lcbu_lane u_green (
      .clock           (clock),
      .pipe_en         (pipe_en),
      .mode_i          (mode_ff),
      .src_i           (req_src_green),
      .dst_i           (req_dst_green),
      .alpha_i         (req_src_alpha),
      .res_o           (green),
      .alpha_applied_o ()
   );

   lcbu_lane u_blue (
      .clock           (clock),
      .pipe_en         (pipe_en),
      .mode_i          (mode_ff),
      .src_i           (req_src_blue),
      .dst_i           (req_dst_blue),
      .alpha_i         (req_src_alpha),
      .res_o           (blue),
      .alpha_applied_o ()
   );

   // skid: catches the last stage when it is pushed out while the output is stalled
   logic [15:0] skid_r_ff, skid_g_ff, skid_b_ff;
   logic        skid_l_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (!rsp_stall) begin
            skid_v_ff <= 1'b0;
         end
      end else if (v_ff[NS-1] && rsp_stall) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_r_ff <= red;
         skid_g_ff <= green;
         skid_b_ff <= blue;
         skid_l_ff <= lum;
      end
   end

   // output word, the older held word first
   assign rsp_valid         = skid_v_ff || v_ff[NS-1];
   assign rsp_out_red       = skid_v_ff ? skid_r_ff : red;
   assign rsp_out_green     = skid_v_ff ? skid_g_ff : green;
   assign rsp_out_blue      = skid_v_ff ? skid_b_ff : blue;
   assign rsp_alpha_applied = skid_v_ff ? skid_l_ff : lum;

endmodule
`default_nettype wire

// ===== sv/lcbu_checker.sv =====
`default_nettype none
`include "layer_color_blend_unit_defines.svh"
module lcbu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_out_red,
   input wire logic [15:0] rsp_out_green,
   input wire logic [15:0] rsp_out_blue,
   input wire logic        rsp_alpha_applied
);

   // whole result word
   logic [48:0] rsp_word;

   assign rsp_word = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_alpha_applied};

   // a stalled result word holds
   `LCBU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled result word changed")

   // results stay within full scale
   `LCBU_ASSERT(a_range, clock, reset, rsp_valid |-> rsp_out_red <= 16'h8000 && rsp_out_green <= 16'h8000 && rsp_out_blue <= 16'h8000, "result channel above full scale")

   // input only backs up when a result word is waiting
   `LCBU_ASSERT(a_no_idle_stall, clock, reset, !rsp_valid |-> !req_stall, "input stalled with empty output")

   // reset empties the block
   `LCBU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "block not empty after reset")

endmodule

bind layer_color_blend_unit lcbu_checker u_lcbu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_red       (rsp_out_red),
   .rsp_out_green     (rsp_out_green),
   .rsp_out_blue      (rsp_out_blue),
   .rsp_alpha_applied (rsp_alpha_applied)
);
`default_nettype wire

// ===== bench/blend_check.sv =====
`timescale 1ns / 1ps
module blend_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [4:0]  csr_blend_mode,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [15:0] req_src_red,
   input  wire logic [15:0] req_src_green,
   input  wire logic [15:0] req_src_blue,
   input  wire logic [15:0] req_dst_red,
   input  wire logic [15:0] req_dst_green,
   input  wire logic [15:0] req_dst_blue,
   input  wire logic [15:0] req_src_alpha,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_out_red,
   input  wire logic [15:0] rsp_out_green,
   input  wire logic [15:0] rsp_out_blue,
   input  wire logic        rsp_alpha_applied,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        applied;
   } pixel_type;

   localparam longint FULL = 32768;
   localparam longint HALF = 16384;

   logic [4:0] mode_shadow;
   pixel_type  pixels_due[$];

   function automatic longint clamp_in(logic [15:0] v);
      clamp_in = (v > 16'h8000) ? FULL : longint'(v);
   endfunction

   function automatic longint quotient(longint num, longint den);
      quotient = (den <= 0 || num < 0) ? 0 : num / den;
   endfunction

   function automatic longint dodge_of(longint s, longint d);
      dodge_of = (s == FULL) ? FULL : quotient(d * 32768, FULL - s);
   endfunction

   // one channel of the selected blend, before output clamp
   function automatic longint blend_chan(lcbu_pkg::mode_type m, longint s, longint d,
                                         longint a);
      longint n;
      n = 0;
      case (m)
         lcbu_pkg::MODE_MULTIPLY:     blend_chan = (s * d) >>> 15;
         lcbu_pkg::MODE_ADD:          blend_chan = s + d;
         lcbu_pkg::MODE_SUBTRACT:     blend_chan = d - s;
         lcbu_pkg::MODE_SCREEN:       blend_chan = s + d - ((s * d) >>> 15);
         lcbu_pkg::MODE_OVERLAY:
            blend_chan = (d < HALF) ? (s * d) >>> 14
                                    : FULL - (((FULL - d) * (FULL - s)) >>> 14);
         lcbu_pkg::MODE_HARD_LIGHT:
            blend_chan = (s < HALF) ? (s * d) >>> 14
                                    : FULL - (((FULL - d) * (FULL - s)) >>> 14);
         lcbu_pkg::MODE_SOFT_LIGHT: begin
            n = (s * d) >>> 15;
            blend_chan = n + ((d * (FULL - n - (((FULL - s) * (FULL - d)) >>> 15))) >>> 15);
         end
         lcbu_pkg::MODE_DODGE:        blend_chan = dodge_of(s, d);
         lcbu_pkg::MODE_BURN:
            blend_chan = (s == 0) ? 0 : FULL - quotient((FULL - d) * 32768, s);
         lcbu_pkg::MODE_LINEAR_BURN:  blend_chan = d + s - FULL;
         lcbu_pkg::MODE_VIVID_LIGHT: begin
            if (s < HALF) begin
               n = FULL - 2 * s;
               blend_chan = (d <= n || s == 0) ? 0 : quotient((d - n) * 32768, 2 * s);
            end else begin
               n = 2 * FULL - 2 * s;
               blend_chan = (d >= n || n == 0) ? FULL : quotient(d * 32768, n);
            end
         end
         lcbu_pkg::MODE_LINEAR_LIGHT: blend_chan = 2 * s + d - FULL;
         lcbu_pkg::MODE_PIN_LIGHT: begin
            if (s > HALF) begin
               n = 2 * s - FULL;
               blend_chan = (n < d) ? d : n;
            end else begin
               n = 2 * s;
               blend_chan = (n > d) ? d : n;
            end
         end
         lcbu_pkg::MODE_DARKEN:       blend_chan = (d < s) ? d : s;
         lcbu_pkg::MODE_LIGHTEN:      blend_chan = (d > s) ? d : s;
         lcbu_pkg::MODE_DIFFERENCE:   blend_chan = (s >= d) ? s - d : d - s;
         lcbu_pkg::MODE_LUM_ADD:      blend_chan = ((s * a) >>> 15) + d;
         lcbu_pkg::MODE_LUM_DODGE:    blend_chan = dodge_of((s * a) >>> 15, d);
         default:                     blend_chan = s;
      endcase
   endfunction

   function automatic logic [15:0] blend_out(lcbu_pkg::mode_type m, logic [15:0] s,
                                             logic [15:0] d, logic [15:0] a);
      longint v;
      v = blend_chan(m, clamp_in(s), clamp_in(d), clamp_in(a));
      if (v < 0) v = 0;
      if (v > FULL) v = FULL;
      blend_out = v[15:0];
   endfunction

   assign pending_count = pixels_due.size();

   // track the mode, predict accepted words, compare delivered words
   always @(posedge clock) begin
      pixel_type          want;
      pixel_type          got;
      lcbu_pkg::mode_type m;
      if (reset) begin
         mode_shadow <= lcbu_pkg::MODE_NORMAL;
         pixels_due.delete();
      end else begin
         if (csr_write_enable) mode_shadow <= csr_blend_mode;
         if (req_valid && !req_stall) begin
            m = (mode_shadow >= lcbu_pkg::MODE_COUNT) ? lcbu_pkg::MODE_NORMAL
                                                       : lcbu_pkg::mode_type'(mode_shadow);
            want.red     = blend_out(m, req_src_red, req_dst_red, req_src_alpha);
            want.green   = blend_out(m, req_src_green, req_dst_green, req_src_alpha);
            want.blue    = blend_out(m, req_src_blue, req_dst_blue, req_src_alpha);
            want.applied = (m == lcbu_pkg::MODE_LUM_ADD || m == lcbu_pkg::MODE_LUM_DODGE);
            pixels_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_alpha_applied};
            if (pixels_due.size() == 0) begin
               fail_count <= fail_count + 1;
               $display("%0t: unexpected word %h", $time, got);
            end else begin
               want = pixels_due.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  $display("%0t: mismatch expected r=%h g=%h b=%h a=%b got r=%h g=%h b=%h a=%b",
                           $time, want.red, want.green, want.blue, want.applied,
                           got.red, got.green, got.blue, got.applied);
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [4:0]  csr_blend_mode = 5'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_src_red = 16'd0;
   logic [15:0] req_src_green = 16'd0;
   logic [15:0] req_src_blue = 16'd0;
   logic [15:0] req_dst_red = 16'd0;
   logic [15:0] req_dst_green = 16'd0;
   logic [15:0] req_dst_blue = 16'd0;
   logic [15:0] req_src_alpha = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_red;
   logic [15:0] rsp_out_green;
   logic [15:0] rsp_out_blue;
   logic        rsp_alpha_applied;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          stall_left = 0;
   logic        calm = 1'b0;

   always #10 clock = ~clock;

   layer_color_blend_unit i_dut (.*);

   blend_check i_check (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[layer_color_blend_unit] ERROR");
         $finish;
      end
   end

   // receiver stalls, with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && !rsp_stall) stall_left <= calm ? 0 : $urandom_range(0, 13);
      end
   end

   // channel value biased toward edges and mode thresholds
   function automatic logic [15:0] pick_chan();
      case ($urandom_range(0, 11))
         0:       pick_chan = 16'h0000;
         1:       pick_chan = 16'h8000;
         2:       pick_chan = 16'h4000;
         3:       pick_chan = 16'h3fff;
         4:       pick_chan = 16'h2000;
         5:       pick_chan = 16'h7fff;
         6:       pick_chan = 16'($urandom_range(0, 65535));
         default: pick_chan = 16'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic set_mode(logic [4:0] m);
      wait (pending_count == 0);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_blend_mode   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_word(logic [15:0] sr, logic [15:0] sg, logic [15:0] sb,
                            logic [15:0] dr, logic [15:0] dg, logic [15:0] db,
                            logic [15:0] sa);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_src_red   <= sr;
      req_src_green <= sg;
      req_src_blue  <= sb;
      req_dst_red   <= dr;
      req_dst_green <= dg;
      req_dst_blue  <= db;
      req_src_alpha <= sa;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int m;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed word per mode, out-of-range modes included
      for (m = 0; m < 21; m++) begin
         set_mode((m == 20) ? 5'd31 : 5'(m));
         send_word(16'h0000, 16'h8000, 16'h4000, 16'hffff, 16'h0000, 16'h4000, 16'hffff);
         drop_valid();
      end
      // random phases, mostly the defined modes with some extremes
      for (n = 0; n < 42; n++) begin
         calm = ($urandom_range(0, 3) == 0);
         set_mode((n < 19) ? 5'(n) : 5'($urandom_range(0, 31)));
         repeat (20) send_word(pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                               pick_chan(), pick_chan(), pick_chan());
         drop_valid();
      end
      calm = 1'b0;
      wait (pending_count == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("[layer_color_blend_unit] OK");
      end else begin
         $display("[layer_color_blend_unit] ERROR");
      end
      $finish;
   end

endmodule
